### rtl/qph_pkg.sv
// Shared types and constants for the quadratic probe hash table.
`default_nettype none
package qph_pkg;

   localparam int KEY_W   = 32;
   localparam int VALUE_W = 32;
   localparam int SIZE_W  = 11;
   localparam int SLOT_W  = 10;
   localparam int STAT_W  = 3;
   localparam int KBIT_W  = $clog2(KEY_W);

   localparam logic [SIZE_W-1:0] SIZE_RESET = 11'd11;
   localparam logic [SIZE_W-1:0] SIZE_MIN   = 11'd2;

   // request actions
   localparam logic [1:0] ACT_INSERT = 2'd0;
   localparam logic [1:0] ACT_SEARCH = 2'd1;
   localparam logic [1:0] ACT_REMOVE = 2'd2;

   // result codes
   localparam logic [STAT_W-1:0] RES_INSERTED  = 3'd0;
   localparam logic [STAT_W-1:0] RES_UPDATED   = 3'd1;
   localparam logic [STAT_W-1:0] RES_FOUND     = 3'd2;
   localparam logic [STAT_W-1:0] RES_NOT_FOUND = 3'd3;
   localparam logic [STAT_W-1:0] RES_REMOVED   = 3'd4;
   localparam logic [STAT_W-1:0] RES_FULL      = 3'd5;

   // slot states
   localparam logic [1:0] SLOT_EMPTY    = 2'd0;
   localparam logic [1:0] SLOT_OCCUPIED = 2'd1;
   localparam logic [1:0] SLOT_DELETED  = 2'd2;

   typedef struct packed {
      logic [1:0]         action;
      logic [KEY_W-1:0]   key;
      logic [VALUE_W-1:0] entry_value;
   } qph_req_type;

   typedef struct packed {
      logic [STAT_W-1:0]  status;
      logic [VALUE_W-1:0] found_value;
      logic [SLOT_W-1:0]  slot_index;
      logic [SIZE_W-1:0]  probe_count;
      logic               over_threshold;
   } qph_rsp_type;

   // item handed from the front to the back
   typedef struct packed {
      logic [1:0]         action;
      logic [KEY_W-1:0]   key;
      logic [VALUE_W-1:0] entry_value;
      logic [SIZE_W-1:0]  home;
   } qph_job_type;

   typedef enum logic [1:0] {
      F_IDLE,
      F_DIV,
      F_PUSH
   } qph_front_state_type;

   typedef enum logic [2:0] {
      B_CLEAR,
      B_IDLE,
      B_READ,
      B_EVAL,
      B_FINISH
   } qph_back_state_type;

endpackage
`default_nettype wire

### rtl/qph_ram.sv
// Generic single write port, single read port RAM with registered read.
`default_nettype none
module qph_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule
`default_nettype wire

### rtl/qph_front.sv
// Front end: accepts items and computes the home slot, key mod size.
`default_nettype none
module qph_front
   import qph_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic [SIZE_W-1:0] size,
   input  wire logic              hold,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire qph_req_type       req_data,
   output logic                   push,
   output qph_job_type            job,
   input  wire logic              queue_full
);

   qph_front_state_type state_ff, state_in;
   qph_req_type         item_ff, item_in;
   logic [KEY_W-1:0]    shift_ff, shift_in;
   logic [SIZE_W-1:0]   rem_ff, rem_in;
   logic [KBIT_W-1:0]   bit_ff, bit_in;
   logic [SIZE_W:0]     trial;
   logic                accept;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != F_IDLE) || hold;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         F_IDLE: if (accept) state_in = F_DIV;
         F_DIV:  if (bit_ff == KBIT_W'(KEY_W - 1)) state_in = F_PUSH;
         F_PUSH: if (!queue_full) state_in = F_IDLE;
         default: state_in = F_IDLE;
      endcase
   end

   // restoring remainder, one key bit a cycle
   always_comb begin
      item_in  = item_ff;
      shift_in = shift_ff;
      rem_in   = rem_ff;
      bit_in   = bit_ff;
      trial    = {rem_ff, shift_ff[KEY_W-1]};
      push     = 1'b0;
      unique case (state_ff)
         F_IDLE: begin
            if (accept) begin
               item_in  = req_data;
               shift_in = req_data.key;
               rem_in   = '0;
               bit_in   = '0;
            end
         end
         F_DIV: begin
            shift_in = {shift_ff[KEY_W-2:0], 1'b0};
            bit_in   = bit_ff + 1'b1;
            if (trial >= {1'b0, size}) begin
               rem_in = SIZE_W'(trial - {1'b0, size});
            end else begin
               rem_in = SIZE_W'(trial);
            end
         end
         F_PUSH: push = !queue_full;
         default: ;
      endcase
   end

   assign job.action      = item_ff.action;
   assign job.key         = item_ff.key;
   assign job.entry_value = item_ff.entry_value;
   assign job.home        = rem_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
      item_ff  <= item_in;
      shift_ff <= shift_in;
      rem_ff   <= rem_in;
      bit_ff   <= bit_in;
   end

endmodule
`default_nettype wire

### rtl/qph_queue.sv
// Two-entry queue between front and back.
`default_nettype none
module qph_queue
   import qph_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        push,
   input  wire qph_job_type push_job,
   output logic             full,
   input  wire logic        pop,
   output logic             not_empty,
   output qph_job_type      head
);

   qph_job_type entry_ff [2];
   logic        wr_ptr_ff, rd_ptr_ff;
   logic [1:0]  count_ff;

   assign full      = (count_ff == 2'd2);
   assign not_empty = (count_ff != 2'd0);
   assign head      = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= !wr_ptr_ff;
         if (pop) rd_ptr_ff <= !rd_ptr_ff;
         if (push && !pop) begin
            count_ff <= count_ff + 2'd1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 2'd1;
         end
      end
      if (push) entry_ff[wr_ptr_ff] <= push_job;
   end

endmodule
`default_nettype wire

### rtl/qph_back.sv
// Back end: probe walk over the slot memories and result register.
`default_nettype none
module qph_back
   import qph_pkg::*;
#(
   parameter int CAPACITY = 1024
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic [SIZE_W-1:0] size,
   input  wire logic              job_valid,
   input  wire qph_job_type       job,
   output logic                   job_pop,
   output logic                   clear_busy,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output qph_rsp_type            rsp_data
);

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int MW = ((CW > SIZE_W) ? CW : SIZE_W) + 4;

   qph_back_state_type state_ff, state_in;
   qph_job_type        job_ff, job_in;
   logic [SIZE_W-1:0]  x_ff, x_in, inc_ff, inc_in, probe_ff, probe_in;
   logic [AW-1:0]      clr_ff, clr_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [STAT_W-1:0]  res_status_ff, res_status_in;
   logic [VALUE_W-1:0] res_value_ff, res_value_in;
   logic [SIZE_W-1:0]  res_slot_ff, res_slot_in, res_probes_ff, res_probes_in;
   logic               rsp_valid_ff, rsp_valid_in;
   qph_rsp_type        rsp_data_ff, rsp_data_in;

   logic               key_we, value_we, stat_we;
   logic [AW-1:0]      waddr, raddr;
   logic [1:0]         stat_wdata, stat_rd;
   logic [KEY_W-1:0]   key_rd;
   logic [VALUE_W-1:0] value_rd;

   logic               occ, empty, match, last, done, load, known;
   logic [SIZE_W:0]    x_sum, inc_sum;
   logic [MW-1:0]      load_lhs, load_rhs;

   qph_ram #(.WIDTH(KEY_W), .DEPTH(CAPACITY)) u_keys (
      .clock(clock), .we(key_we), .waddr(waddr), .wdata(job_ff.key),
      .raddr(raddr), .rdata(key_rd));
   qph_ram #(.WIDTH(VALUE_W), .DEPTH(CAPACITY)) u_values (
      .clock(clock), .we(value_we), .waddr(waddr), .wdata(job_ff.entry_value),
      .raddr(raddr), .rdata(value_rd));
   qph_ram #(.WIDTH(2), .DEPTH(CAPACITY)) u_status (
      .clock(clock), .we(stat_we), .waddr(waddr), .wdata(stat_wdata),
      .raddr(raddr), .rdata(stat_rd));

   assign occ   = (stat_rd == SLOT_OCCUPIED);
   assign empty = (stat_rd == SLOT_EMPTY);
   assign match = (key_rd == job_ff.key);
   assign last  = (probe_ff == size - 1'b1);
   assign done  = (job_ff.action == ACT_INSERT) ? (!occ || match) : (empty || (occ && match));
   assign known = (job.action == ACT_INSERT) || (job.action == ACT_SEARCH) ||
                  (job.action == ACT_REMOVE);
   assign load  = (state_ff == B_FINISH) && (!rsp_valid_ff || !rsp_stall);

   // next probe: x += 2i+1 and the step itself grows by 2, both mod size
   assign x_sum   = {1'b0, x_ff} + {1'b0, inc_ff};
   assign inc_sum = {1'b0, inc_ff} + (SIZE_W + 1)'(2);

   assign load_lhs = (MW'(count_ff) << 3) + (MW'(count_ff) << 1);
   assign load_rhs = (MW'(size) << 3) - MW'(size);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         B_CLEAR:  if (clr_ff == AW'(CAPACITY - 1)) state_in = B_IDLE;
         B_IDLE:   if (job_valid) state_in = known ? B_READ : B_FINISH;
         B_READ:   state_in = B_EVAL;
         B_EVAL:   state_in = (done || last) ? B_FINISH : B_READ;
         B_FINISH: if (load) state_in = B_IDLE;
         default:  state_in = B_IDLE;
      endcase
   end

   always_comb begin
      job_in        = job_ff;
      x_in          = x_ff;
      inc_in        = inc_ff;
      probe_in      = probe_ff;
      clr_in        = clr_ff;
      count_in      = count_ff;
      res_status_in = res_status_ff;
      res_value_in  = res_value_ff;
      res_slot_in   = res_slot_ff;
      res_probes_in = res_probes_ff;
      job_pop       = 1'b0;
      key_we        = 1'b0;
      value_we      = 1'b0;
      stat_we       = 1'b0;
      stat_wdata    = SLOT_EMPTY;
      waddr         = AW'(x_ff);
      raddr         = AW'(x_ff);
      unique case (state_ff)
         B_CLEAR: begin
            stat_we = 1'b1;
            waddr   = clr_ff;
            clr_in  = clr_ff + 1'b1;
         end
         B_IDLE: begin
            job_pop       = job_valid;
            job_in        = job;
            x_in          = job.home;
            inc_in        = SIZE_W'(1);
            probe_in      = '0;
            res_status_in = RES_NOT_FOUND;
            res_value_in  = '0;
            res_slot_in   = '0;
            res_probes_in = '0;
         end
         B_EVAL: begin
            if (done) begin
               res_slot_in   = x_ff;
               res_probes_in = probe_ff;
               if (job_ff.action == ACT_INSERT) begin
                  value_we = 1'b1;
                  if (occ) begin
                     res_status_in = RES_UPDATED;
                  end else begin
                     key_we        = 1'b1;
                     stat_we       = 1'b1;
                     stat_wdata    = SLOT_OCCUPIED;
                     count_in      = count_ff + 1'b1;
                     res_status_in = RES_INSERTED;
                  end
               end else if (empty) begin
                  res_slot_in   = '0;
                  res_status_in = RES_NOT_FOUND;
               end else if (job_ff.action == ACT_SEARCH) begin
                  res_status_in = RES_FOUND;
                  res_value_in  = value_rd;
               end else begin
                  stat_we       = 1'b1;
                  stat_wdata    = SLOT_DELETED;
                  if (count_ff != '0) count_in = count_ff - 1'b1;
                  res_status_in = RES_REMOVED;
               end
            end else if (last) begin
               res_probes_in = size;
               res_status_in = (job_ff.action == ACT_INSERT) ? RES_FULL : RES_NOT_FOUND;
            end else begin
               probe_in = probe_ff + 1'b1;
               x_in     = (x_sum >= {1'b0, size}) ? SIZE_W'(x_sum - {1'b0, size})
                                                  : SIZE_W'(x_sum);
               inc_in   = (inc_sum >= {1'b0, size}) ? SIZE_W'(inc_sum - {1'b0, size})
                                                    : SIZE_W'(inc_sum);
            end
         end
         default: ;
      endcase
   end

   always_comb begin
      rsp_valid_in = load || (rsp_valid_ff && rsp_stall);
      rsp_data_in  = rsp_data_ff;
      if (load) begin
         rsp_data_in.status         = res_status_ff;
         rsp_data_in.found_value    = res_value_ff;
         rsp_data_in.slot_index     = SLOT_W'(res_slot_ff);
         rsp_data_in.probe_count    = res_probes_ff;
         rsp_data_in.over_threshold = (load_lhs > load_rhs);
      end
   end

   assign clear_busy = (state_ff == B_CLEAR);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_CLEAR;
         clr_ff       <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      job_ff        <= job_in;
      x_ff          <= x_in;
      inc_ff        <= inc_in;
      probe_ff      <= probe_in;
      res_status_ff <= res_status_in;
      res_value_ff  <= res_value_in;
      res_slot_ff   <= res_slot_in;
      res_probes_ff <= res_probes_in;
      rsp_data_ff   <= rsp_data_in;
   end

endmodule
`default_nettype wire

### rtl/quadratic_probe_hash_table.sv
// Top level of the quadratic probe hash table.
// Usage:
//  - req channel (valid/stall) carries action, key and entry_value; one rsp
//    item comes back per req item, in order, on the rsp channel.
//  - csr_wen/csr_wdata write the table size (slots in use); write only
//    while the block is idle. Sizes below 2 act as 2, above CAPACITY as
//    CAPACITY.
//  - The front computes the home slot remainder one key bit a cycle between
//    accept and hand-off, and takes no new item until it has handed the
//    last one to the queue. For each probe the back does a registered
//    memory read, then compare and write; the walk stops at the first
//    usable slot or after size probes, and an unused action skips it.
//    Front and back overlap through a two-entry queue.
//  - After reset the slot status memory is cleared, one slot a cycle;
//    req_stall stays high meanwhile.
//  - When the receiver stalls, the result waits in the output register;
//    the back stops once it has the next result ready, then the queue and
//    finally the front fill up and req_stall rises.
`default_nettype none
module quadratic_probe_hash_table
   import qph_pkg::*;
#(
   parameter int CAPACITY = 1024
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire qph_req_type       req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output qph_rsp_type            rsp_data,
   input  wire logic              csr_wen,
   input  wire logic [SIZE_W-1:0] csr_wdata
);

   logic [SIZE_W-1:0] size_ff, size;
   logic              push, full, pop, not_empty, clear_busy;
   qph_job_type       push_job, head;

   always_comb begin
      if (size_ff < SIZE_MIN) begin
         size = SIZE_MIN;
      end else if (32'(size_ff) > 32'(CAPACITY)) begin
         size = SIZE_W'(CAPACITY);
      end else begin
         size = size_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= SIZE_RESET;
      end else if (csr_wen) begin
         size_ff <= csr_wdata;
      end
   end

   qph_front u_front (
      .clock(clock), .reset(reset), .size(size), .hold(clear_busy),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .push(push), .job(push_job), .queue_full(full));

   qph_queue u_queue (
      .clock(clock), .reset(reset), .push(push), .push_job(push_job),
      .full(full), .pop(pop), .not_empty(not_empty), .head(head));

   qph_back #(.CAPACITY(CAPACITY)) u_back (
      .clock(clock), .reset(reset), .size(size), .job_valid(not_empty),
      .job(head), .job_pop(pop), .clear_busy(clear_busy),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data));

endmodule
`default_nettype wire

### rtl/qph_checker.sv
// Port-level checks for the quadratic probe hash table, bound to the top.
`default_nettype none
module qph_checker
   import qph_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_stall,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire qph_rsp_type rsp_data
);

   // a held result stays up
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("rsp item dropped while stalled");

   // front is busy computing the home slot right after an accept
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second item accepted back to back");

   // no result right after reset, when the status memory clear begins
   a_no_rsp_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp item right after reset");

   a_status_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.status <= RES_FULL)
      else $error("illegal result code");

   a_value_only_found: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != RES_FOUND |-> rsp_data.found_value == '0)
      else $error("found_value set without a hit");

endmodule

bind quadratic_probe_hash_table qph_checker u_qph_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
   .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data));
`default_nettype wire
